// File: hw/rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int STAMP_W  = 32;
    localparam int ACTION_W = 2;
    localparam int OCC_W    = 5;

    localparam int DEFAULT_ENTRIES = 16;

    // Action codes. Code 3 has no meaning and is answered as a no-op.
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  new_value;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] read_value;
        logic               evicted;
        logic [OCC_W-1:0]   occupancy;
    } resp_t;

    // One stored entry: key, value and access-order stamp.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

endpackage

// File: hw/rtl/lkvc_store.sv
// Entry memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module lkvc_store #(
    parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES,
    parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [IW-1:0]     wr_addr,
    input  lkvc_pkg::entry_t  wr_data,
    input  logic              rd_en,
    input  logic [IW-1:0]     rd_addr,
    output lkvc_pkg::entry_t  rd_data
);

    lkvc_pkg::entry_t mem [ENTRIES];
    lkvc_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/lru_key_value_cache.sv
// Top level of the LRU key/value cache: control, valid bits and entry scan.
`timescale 1ns / 1ps

// Channel   Ports                    Direction  Payload
// request   s_valid s_ready s_data   in         lkvc_pkg::req_t  (action, key, new_value)
// result    m_valid m_ready m_data   out        lkvc_pkg::resp_t (hit, read_value,
//                                               evicted, occupancy)
//
// A lookup or update walks the memory's single read port one entry per cycle in ST_SCAN,
// then waits in ST_DRAIN for the last read data and writes back in ST_FINISH, after which
// the block returns to ST_IDLE before it takes the next request. A clear or an unused
// action code goes from ST_IDLE straight to ST_FINISH. Only one item is in work at a
// time; a finished result waits in the output register, and the next request is taken
// meanwhile, but its write-back waits until that result has been taken. Reset clears
// the valid bits, the entry count and the access counter at once, so the block is
// ready as soon as reset is released.
//
// Each stored entry holds its key, its value and an access-order stamp copied from
// a running counter whenever the entry is used. The scan finds the matching key,
// the lowest free slot and the entry of greatest age (counter minus stamp) in one
// pass; the finishing step then writes back at most one whole entry.

module lru_key_value_cache #(
    parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lkvc_pkg::req_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output lkvc_pkg::resp_t  m_data
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // Request held for the whole operation.
    lkvc_pkg::req_t req_reg;

    // Scan bookkeeping.
    logic [IW-1:0]                addr_reg;
    logic                         rd_pending_reg;
    logic [IW-1:0]                rd_idx_reg;
    logic                         hit_found_reg;
    logic [IW-1:0]                hit_idx_reg;
    logic [lkvc_pkg::VALUE_W-1:0] hit_value_reg;
    logic                         free_found_reg;
    logic [IW-1:0]                free_idx_reg;
    logic                         old_found_reg;
    logic [IW-1:0]                old_idx_reg;
    logic [lkvc_pkg::STAMP_W-1:0] old_age_reg;

    // Architectural state kept in flip-flops.
    logic [ENTRIES-1:0]           valid_reg;
    logic [CW-1:0]                count_reg;
    logic [lkvc_pkg::STAMP_W-1:0] counter_reg;

    // Output register.
    logic             m_valid_reg;
    lkvc_pkg::resp_t  m_data_reg;

    // Memory ports.
    logic              mem_rd_en;
    lkvc_pkg::entry_t  mem_rd_data;
    logic              mem_wr_en;
    logic [IW-1:0]     mem_wr_addr;
    lkvc_pkg::entry_t  mem_wr_data;

    lkvc_store #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (addr_reg),
        .rd_data (mem_rd_data)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign mem_rd_en = (state_reg == ST_SCAN);

    // Per-entry evaluation of the read data that just came back.
    logic                         ent_valid;
    logic                         ent_match;
    logic [lkvc_pkg::STAMP_W-1:0] ent_age;

    assign ent_valid = valid_reg[rd_idx_reg];
    assign ent_match = ent_valid && (mem_rd_data.key == req_reg.key);
    assign ent_age   = counter_reg - mem_rd_data.stamp;

    // Finishing step: decide the write-back and the result.
    logic                         fin_go;
    logic                         touch;
    logic                         set_valid;
    logic [IW-1:0]                ins_slot;
    logic [ENTRIES-1:0]           valid_next;
    logic [CW-1:0]                count_next;
    logic [CW+lkvc_pkg::OCC_W-1:0] count_ext;
    lkvc_pkg::resp_t              resp_next;

    assign fin_go   = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);
    assign ins_slot = free_found_reg ? free_idx_reg : old_idx_reg;

    always_comb begin
        touch       = 1'b0;
        set_valid   = 1'b0;
        mem_wr_addr = hit_idx_reg;
        mem_wr_data.key   = req_reg.key;
        mem_wr_data.value = req_reg.new_value;
        mem_wr_data.stamp = counter_reg;
        valid_next  = valid_reg;
        count_next  = count_reg;
        resp_next   = '0;
        unique case (req_reg.action)
            lkvc_pkg::ACT_LOOKUP: begin
                if (hit_found_reg) begin
                    touch                = 1'b1;
                    mem_wr_data.value    = hit_value_reg;
                    resp_next.hit        = 1'b1;
                    resp_next.read_value = hit_value_reg;
                end
            end
            lkvc_pkg::ACT_UPDATE: begin
                touch = 1'b1;
                if (hit_found_reg) begin
                    resp_next.hit = 1'b1;
                end else begin
                    set_valid         = 1'b1;
                    mem_wr_addr       = ins_slot;
                    valid_next[ins_slot] = 1'b1;
                    resp_next.evicted = !free_found_reg;
                    if (free_found_reg) begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            lkvc_pkg::ACT_CLEAR: begin
                valid_next = '0;
                count_next = '0;
            end
            default: begin
                // Unused action code: nothing changes.
            end
        endcase
        count_ext           = (CW + lkvc_pkg::OCC_W)'(count_next);
        resp_next.occupancy = count_ext[lkvc_pkg::OCC_W-1:0];
    end

    assign mem_wr_en = fin_go && touch;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rd_pending_reg <= 1'b0;
            valid_reg      <= '0;
            count_reg      <= '0;
            counter_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            // A result taken in the same cycle as a new one is loaded is replaced below.
            if (m_valid_reg && m_ready && !fin_go) begin
                m_valid_reg <= 1'b0;
            end

            rd_pending_reg <= (state_reg == ST_SCAN);
            rd_idx_reg     <= addr_reg;

            // Fold in one entry per cycle while reads are returning.
            if (rd_pending_reg) begin
                if (ent_match && !hit_found_reg) begin
                    hit_found_reg <= 1'b1;
                    hit_idx_reg   <= rd_idx_reg;
                    hit_value_reg <= mem_rd_data.value;
                end
                if (!ent_valid && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= rd_idx_reg;
                end
                if (ent_valid && (!old_found_reg || ent_age > old_age_reg)) begin
                    old_found_reg <= 1'b1;
                    old_idx_reg   <= rd_idx_reg;
                    old_age_reg   <= ent_age;
                end
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        req_reg        <= s_data;
                        addr_reg       <= '0;
                        hit_found_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        old_found_reg  <= 1'b0;
                        if (s_data.action == lkvc_pkg::ACT_LOOKUP ||
                            s_data.action == lkvc_pkg::ACT_UPDATE) begin
                            state_reg <= ST_SCAN;
                        end else begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_SCAN: begin
                    if (addr_reg == IW'(ENTRIES - 1)) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (fin_go) begin
                        valid_reg   <= valid_next;
                        count_reg   <= count_next;
                        if (touch) begin
                            counter_reg <= counter_reg + 1'b1;
                        end
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= resp_next;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The entry count always equals the number of set valid bits.
    a_count_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == CW'($countones(valid_reg)))
        else $error("entry count differs from valid bits");

    // An eviction happens only when the store is full.
    a_evict_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_go && set_valid && !free_found_reg) |-> (count_reg == CW'(ENTRIES)))
        else $error("eviction from a store that is not full");

    // A result never reports both a hit and an eviction.
    a_hit_not_evicted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.hit && m_data.evicted))
        else $error("result reports hit and eviction together");

    // After a request transfer, no further request is taken in the next cycle.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while another is in work");

endmodule

// File: bench/lru_key_value_cache_test.sv
// Self-checking bench for the LRU key/value cache: random and directed accesses against a predictor.
`timescale 1ns / 1ps

module lru_key_value_cache_test;

    import lkvc_pkg::*;

    localparam int ENTRIES = DEFAULT_ENTRIES;

    // The package names three actions; the fourth code must be answered as a no-op.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // The drain after the last result leaves ample room for a lookup or update still in work.
    localparam int DRAIN_CYCLES = 4 * (ENTRIES + 3);

    // About 1675 items, plus stalls on both sides; this limit is many times the slowest
    // correct run.
    localparam int CYCLE_LIMIT = 600000;

    // Both sides run without any idling in this window of cycles.
    localparam int QUIET_FROM = 3000;
    localparam int QUIET_TO   = 7000;

    localparam int RANDOM_ITEMS  = 1650;
    localparam int SEGMENT_ITEMS = 150;

    logic  aclk    = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    req_t  s_data  = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    resp_t m_data;

    int cycle_count = 0;
    int fail_count  = 0;

    // Requests not yet transferred, and the results predicted for transferred requests.
    req_t  ops_to_send[$];
    resp_t replies_due[$];

    // The predictor's own copy of the cache contents.
    logic                model_valid [ENTRIES];
    logic [KEY_W-1:0]    model_key   [ENTRIES];
    logic [VALUE_W-1:0]  model_value [ENTRIES];
    logic [STAMP_W-1:0]  model_stamp [ENTRIES];
    logic [STAMP_W-1:0]  model_clock;
    logic [OCC_W-1:0]    model_count;

    lru_key_value_cache #(
        .ENTRIES (ENTRIES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Applies one access to the predicted cache and returns the result it must produce.
    task automatic lru_cache_access(input req_t op, output resp_t reply);
        int                 match;
        int                 slot;
        int                 victim;
        logic [STAMP_W-1:0] age;
        logic [STAMP_W-1:0] oldest_age;
        match  = -1;
        slot   = -1;
        victim = -1;
        oldest_age = '0;
        reply = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (model_valid[i] && model_key[i] == op.key && match < 0) begin
                match = i;
            end
        end
        case (op.action)
            ACT_LOOKUP: begin
                if (match >= 0) begin
                    reply.hit        = 1'b1;
                    reply.read_value = model_value[match];
                    model_stamp[match] = model_clock;
                    model_clock = model_clock + 1'b1;
                end
            end
            ACT_UPDATE: begin
                if (match >= 0) begin
                    reply.hit = 1'b1;
                    slot = match;
                end else begin
                    // The lowest free slot wins; with none free, the oldest entry goes,
                    // the lowest index breaking a tie in age.
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!model_valid[i] && slot < 0) begin
                            slot = i;
                        end
                    end
                    if (slot < 0) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            age = model_clock - model_stamp[i];
                            if (victim < 0 || age > oldest_age) begin
                                victim     = i;
                                oldest_age = age;
                            end
                        end
                        slot = victim;
                        reply.evicted = 1'b1;
                    end else begin
                        model_count = model_count + 1'b1;
                    end
                    model_valid[slot] = 1'b1;
                    model_key[slot]   = op.key;
                end
                model_value[slot] = op.new_value;
                model_stamp[slot] = model_clock;
                model_clock = model_clock + 1'b1;
            end
            ACT_CLEAR: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    model_valid[i] = 1'b0;
                end
                model_count = '0;
            end
            default: begin
            end
        endcase
        reply.occupancy = model_count;
    endtask

    function automatic void add_op(logic [ACTION_W-1:0] action, logic [KEY_W-1:0] key,
                                   logic [VALUE_W-1:0] value);
        req_t op;
        op.action    = action;
        op.key       = key;
        op.new_value = value;
        ops_to_send.push_back(op);
    endfunction

    // Values lean toward the extremes now and then, otherwise fully random.
    function automatic logic [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5) begin
            return '0;
        end else if (roll < 10) begin
            return '1;
        end
        return $urandom;
    endfunction

    // Each side takes a break with a chance of about 12 percent, except inside the quiet window.
    function automatic bit take_break();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) begin
            return 1'b0;
        end
        return $urandom_range(99) < 12;
    endfunction

    // Driver. At each edge it first books a transfer that just happened, predicting its
    // result, then decides what the channel carries next. Valid is only ever assigned
    // once per edge, so a back-to-back item keeps valid high without a glitch.
    always @(posedge aclk) begin
        resp_t predicted;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                lru_cache_access(s_data, predicted);
                replies_due.push_back(predicted);
                void'(ops_to_send.pop_front());
            end
            if (!s_valid || s_ready) begin
                if (ops_to_send.size() > 0 && !take_break()) begin
                    s_valid <= 1'b1;
                    s_data  <= ops_to_send[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Every result transfer is matched against the oldest prediction.
    always @(posedge aclk) begin
        resp_t due;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    fail_count++;
                end else begin
                    due = replies_due.pop_front();
                    if (m_data.hit !== due.hit) begin
                        $error("hit: expected %0d, got %0d", due.hit, m_data.hit);
                        fail_count++;
                    end
                    if (m_data.read_value !== due.read_value) begin
                        $error("read_value: expected %h, got %h",
                               due.read_value, m_data.read_value);
                        fail_count++;
                    end
                    if (m_data.evicted !== due.evicted) begin
                        $error("evicted: expected %0d, got %0d", due.evicted, m_data.evicted);
                        fail_count++;
                    end
                    if (m_data.occupancy !== due.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               due.occupancy, m_data.occupancy);
                        fail_count++;
                    end
                end
            end
            m_ready <= !take_break();
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [KEY_W-1:0] key_pool[$];
        logic [KEY_W-1:0] key;
        int               pool_size;
        int               roll;

        for (int i = 0; i < ENTRIES; i++) begin
            model_valid[i] = 1'b0;
            model_key[i]   = '0;
            model_value[i] = '0;
            model_stamp[i] = '0;
        end
        model_clock = '0;
        model_count = '0;

        // Directed opening: a miss on the empty store, the extreme keys and values, an
        // update hit, the unused action code, a fill to capacity, a recency refresh that
        // steers the eviction, an eviction from the full store, and a clear.
        add_op(ACT_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        add_op(ACT_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF);
        add_op(ACT_UPDATE, 32'hFFFF_FFFF, 32'h0000_0000);
        add_op(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h1234_5678);
        add_op(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        add_op(ACT_UPDATE, 32'h0000_0000, 32'h5A5A_A5A5);
        add_op(ACT_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF);
        for (int i = 0; i < ENTRIES - 2; i++) begin
            add_op(ACT_UPDATE, 32'hC0DE_0000 + i, $urandom);
        end
        add_op(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        add_op(ACT_UPDATE, 32'h8000_0001, 32'h7FFF_FFFF);
        add_op(ACT_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_op(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000);

        // Random part in segments. Each segment draws a pool of keys, sometimes smaller
        // and sometimes larger than the store, so hits, refreshes and evictions all
        // occur; a few keys are fully random and a few accesses are clears or no-ops.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % SEGMENT_ITEMS == 0) begin
                key_pool.delete();
                pool_size = $urandom_range(3 * ENTRIES, 4);
                for (int p = 0; p < pool_size; p++) begin
                    roll = $urandom_range(99);
                    if (roll < 3) begin
                        key_pool.push_back('0);
                    end else if (roll < 6) begin
                        key_pool.push_back('1);
                    end else begin
                        key_pool.push_back($urandom);
                    end
                end
            end
            roll = $urandom_range(99);
            if ($urandom_range(99) < 8) begin
                key = $urandom;
            end else begin
                key = key_pool[$urandom_range(key_pool.size() - 1)];
            end
            if (roll < 46) begin
                add_op(ACT_LOOKUP, key, $urandom);
            end else if (roll < 96) begin
                add_op(ACT_UPDATE, key, pick_value());
            end else if (roll < 98) begin
                add_op(ACT_CLEAR, key, $urandom);
            end else begin
                add_op(ACT_UNUSED, key, $urandom);
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (ops_to_send.size() != 0 || replies_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
